/* rtl/stl_pkg.sv */
// Shared types, constants and character-class helpers for the source token lexer.
// Used by stl_step, stl_rq and source_token_lexer_core; depends on nothing else.
`default_nettype none

package stl_pkg;

  localparam int MAX_KW_LEN_DEFAULT = 8;
  localparam int KW_COUNT           = 13;
  localparam int KW_MAX_CHARS       = 8;
  localparam int MAX_RES            = 3;
  localparam int RQ_DEPTH           = 4;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_NUM       = 4'd1,
    M_IDENT     = 4'd2,
    M_OP        = 4'd3,
    M_STR       = 4'd4,
    M_STR_ESC   = 4'd5,
    M_CHR       = 4'd6,
    M_CHR_ESC   = 4'd7,
    M_LC_OPEN   = 4'd8,
    M_LC        = 4'd9,
    M_BC_OPEN   = 4'd10,
    M_BC        = 4'd11,
    M_BC_CLOSE  = 4'd12,
    M_HALT      = 4'd13
  } mode_t;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_NUM   = 3'd1,
    K_IDENT = 3'd2,
    K_STR   = 3'd3,
    K_CHR   = 3'd4,
    K_PUNC  = 3'd5,
    K_OP    = 3'd6
  } kind_t;

  // Lexer control state held between words.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] la_byte;
    logic       la_valid;
    logic       topen;
  } lex_state_t;

  // One result word.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       cvalid;
    logic       tfirst;
    logic       tlast;
    logic [3:0] kw;
    logic       err;
    logic       done;
    logic       rlast;
  } res_t;

  // Keyword text, right justified: the last character sits in the low byte.
  localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    64'("ext"), 64'("def"), 64'("if"), 64'("else"), 64'("while"), 64'("loop"),
    64'("for"), 64'("break"), 64'("continue"), 64'("class"), 64'("true"),
    64'("false"), 64'("null")
  };
  localparam int KW_LEN [KW_COUNT] = '{3, 3, 2, 4, 5, 4, 3, 5, 8, 5, 4, 5, 4};

  function automatic logic [7:0] kw_char(int k, int i);
    if (i < KW_LEN[k]) begin
      return KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_identc(logic [7:0] c);
    return is_dig(c) || is_alpha(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic logic is_punc(logic [7:0] c);
    logic r;
    case (c) inside
      8'h2E, 8'h2C, 8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_op(logic [7:0] c);
    logic r;
    case (c) inside
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h26, 8'h7C, 8'h3C, 8'h3E,
      8'h21: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/stl_step.sv */
// Per-word lexer step: next state, identifier store write and up to three result words.
// Purely combinational; uses stl_pkg for types, keyword text and character classes.
`default_nettype none

module stl_step #(
  parameter int MAX_KEYWORD_LEN = stl_pkg::MAX_KW_LEN_DEFAULT,
  localparam int IW = $clog2(MAX_KEYWORD_LEN),
  localparam int CW = $clog2(MAX_KEYWORD_LEN + 2)
) (
  input  stl_pkg::lex_state_t st,
  input  logic [CW-1:0]       ident_count,
  input  logic [7:0]          ident_store [MAX_KEYWORD_LEN],
  input  logic [7:0]          char_in,
  input  logic                end_of_stream,
  output stl_pkg::lex_state_t st_next,
  output logic [CW-1:0]       ident_count_next,
  output logic                store_we,
  output logic [IW-1:0]       store_idx,
  output stl_pkg::res_t       res [stl_pkg::MAX_RES],
  output logic [1:0]          res_n
);

  logic [7:0]         c;
  logic [7:0]         nx;
  logic               hn;
  logic               p_put;
  stl_pkg::kind_t     p_kind;
  logic [7:0]         p_ch;
  logic               p_valid;
  logic               p_last;
  logic               p_err;
  logic [3:0]         p_kw;
  stl_pkg::mode_t     p_mode;
  logic               p_topen;
  logic               do_run;
  stl_pkg::kind_t     run_kind;
  stl_pkg::mode_t     run_mode;
  logic               run_cont;
  logic [CW-1:0]      base;
  logic [CW-1:0]      cnt_new;
  logic               ident_upd;
  logic [3:0]         kw_hit;
  logic               p_first;
  logic               topen1;

  assign c  = st.la_byte;
  assign hn = !end_of_stream;
  assign nx = end_of_stream ? 8'h00 : char_in;

  // Work on the held-back byte, with the new byte as its successor.
  always_comb begin
    p_put    = 1'b0;
    p_kind   = stl_pkg::K_NONE;
    p_ch     = c;
    p_valid  = 1'b0;
    p_last   = 1'b0;
    p_err    = 1'b0;
    p_mode   = st.mode;
    p_topen  = st.topen;
    do_run   = 1'b0;
    run_kind = stl_pkg::K_NONE;
    run_mode = stl_pkg::M_IDLE;
    if (st.la_valid && (st.mode != stl_pkg::M_HALT)) begin
      unique case (st.mode)
        stl_pkg::M_IDLE: begin
          if (stl_pkg::is_ws(c)) begin
            p_mode = stl_pkg::M_IDLE;
          end else if (c == stl_pkg::CH_SLASH && hn && nx == stl_pkg::CH_SLASH) begin
            p_mode = stl_pkg::M_LC_OPEN;
          end else if (c == stl_pkg::CH_SLASH && hn && nx == stl_pkg::CH_STAR) begin
            p_mode = stl_pkg::M_BC_OPEN;
          end else if (c == stl_pkg::CH_DQUOTE) begin
            p_topen = 1'b0;
            p_mode  = stl_pkg::M_STR;
          end else if (c == stl_pkg::CH_SQUOTE) begin
            p_topen = 1'b0;
            p_mode  = stl_pkg::M_CHR;
          end else begin
            p_topen = 1'b0;
            if (stl_pkg::is_dig(c) ||
                (c == stl_pkg::CH_MINUS && hn && stl_pkg::is_dig(nx))) begin
              do_run   = 1'b1;
              run_kind = stl_pkg::K_NUM;
              run_mode = stl_pkg::M_NUM;
            end else if (stl_pkg::is_identc(c)) begin
              do_run   = 1'b1;
              run_kind = stl_pkg::K_IDENT;
              run_mode = stl_pkg::M_IDENT;
            end else if (stl_pkg::is_punc(c)) begin
              p_put   = 1'b1;
              p_kind  = stl_pkg::K_PUNC;
              p_valid = 1'b1;
              p_last  = 1'b1;
            end else if (stl_pkg::is_op(c)) begin
              do_run   = 1'b1;
              run_kind = stl_pkg::K_OP;
              run_mode = stl_pkg::M_OP;
            end else begin
              p_put  = 1'b1;
              p_err  = 1'b1;
              p_mode = stl_pkg::M_HALT;
            end
          end
        end
        stl_pkg::M_NUM: begin
          do_run   = 1'b1;
          run_kind = stl_pkg::K_NUM;
          run_mode = stl_pkg::M_NUM;
        end
        stl_pkg::M_IDENT: begin
          do_run   = 1'b1;
          run_kind = stl_pkg::K_IDENT;
          run_mode = stl_pkg::M_IDENT;
        end
        stl_pkg::M_OP: begin
          do_run   = 1'b1;
          run_kind = stl_pkg::K_OP;
          run_mode = stl_pkg::M_OP;
        end
        stl_pkg::M_STR, stl_pkg::M_CHR: begin
          p_kind = (st.mode == stl_pkg::M_STR) ? stl_pkg::K_STR : stl_pkg::K_CHR;
          if (c == stl_pkg::CH_BSLASH) begin
            p_mode = (st.mode == stl_pkg::M_STR) ? stl_pkg::M_STR_ESC : stl_pkg::M_CHR_ESC;
          end else if ((st.mode == stl_pkg::M_STR && c == stl_pkg::CH_DQUOTE) ||
                       (st.mode == stl_pkg::M_CHR && c == stl_pkg::CH_SQUOTE)) begin
            // Closing quote gives the contentless terminator word.
            p_put  = 1'b1;
            p_ch   = 8'h00;
            p_last = 1'b1;
            p_mode = stl_pkg::M_IDLE;
          end else begin
            p_put   = 1'b1;
            p_valid = 1'b1;
          end
        end
        stl_pkg::M_STR_ESC: begin
          p_put   = 1'b1;
          p_kind  = stl_pkg::K_STR;
          p_valid = 1'b1;
          p_mode  = stl_pkg::M_STR;
        end
        stl_pkg::M_CHR_ESC: begin
          p_put   = 1'b1;
          p_kind  = stl_pkg::K_CHR;
          p_valid = 1'b1;
          p_mode  = stl_pkg::M_CHR;
        end
        stl_pkg::M_LC_OPEN:  p_mode = stl_pkg::M_LC;
        stl_pkg::M_LC:       p_mode = (c == stl_pkg::CH_NL) ? stl_pkg::M_IDLE : stl_pkg::M_LC;
        stl_pkg::M_BC_OPEN:  p_mode = stl_pkg::M_BC;
        stl_pkg::M_BC: begin
          if (c == stl_pkg::CH_STAR && hn && nx == stl_pkg::CH_SLASH) begin
            p_mode = stl_pkg::M_BC_CLOSE;
          end
        end
        stl_pkg::M_BC_CLOSE: p_mode = stl_pkg::M_IDLE;
        default:             p_mode = st.mode;
      endcase
    end

    case (run_kind)
      stl_pkg::K_NUM:   run_cont = stl_pkg::is_dig(nx) || (nx == stl_pkg::CH_MINUS);
      stl_pkg::K_IDENT: run_cont = stl_pkg::is_identc(nx);
      default:          run_cont = stl_pkg::is_op(nx);
    endcase

    if (do_run) begin
      p_put   = 1'b1;
      p_kind  = run_kind;
      p_valid = 1'b1;
      p_last  = !(hn && run_cont);
      p_mode  = p_last ? stl_pkg::M_IDLE : run_mode;
    end
  end

  // Identifier store and keyword compare. The current byte is compared in
  // place of the store entry that it is being written to.
  always_comb begin
    logic hit;
    logic [7:0] cand;
    base      = p_topen ? ident_count : '0;
    ident_upd = do_run && (run_kind == stl_pkg::K_IDENT);
    store_we  = ident_upd && (base < CW'(MAX_KEYWORD_LEN));
    store_idx = base[IW-1:0];
    cnt_new   = (base <= CW'(MAX_KEYWORD_LEN)) ? base + CW'(1) : base;
    kw_hit    = 4'd0;
    for (int k = stl_pkg::KW_COUNT - 1; k >= 0; k--) begin
      hit = (cnt_new == CW'(stl_pkg::KW_LEN[k]));
      for (int i = 0; i < stl_pkg::KW_MAX_CHARS; i++) begin
        cand = (base == CW'(i)) ? c : ident_store[i];
        if (i < stl_pkg::KW_LEN[k] && cand != stl_pkg::kw_char(k, i)) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kw_hit = 4'(k + 1);
      end
    end
    p_kw = (ident_upd && p_last && (cnt_new <= CW'(MAX_KEYWORD_LEN))) ? kw_hit : 4'd0;
  end

  // A backslash inside quotes emits nothing, so the token stays as open as it was.
  assign p_first = (p_kind != stl_pkg::K_NONE) && !p_topen;
  assign topen1  = (p_put && (p_kind != stl_pkg::K_NONE)) ? !p_last : p_topen;

  // Assemble result words and the next state.
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int i = 0; i < stl_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end
    if (p_put) begin
      res[n].kind   = p_kind;
      res[n].ch     = p_ch;
      res[n].cvalid = p_valid;
      res[n].tfirst = p_first;
      res[n].tlast  = (p_kind != stl_pkg::K_NONE) && p_last;
      res[n].kw     = p_kw;
      res[n].err    = p_err;
      n = n + 2'd1;
    end
    st_next          = st;
    ident_count_next = ident_count;
    if (end_of_stream) begin
      if (p_mode == stl_pkg::M_STR || p_mode == stl_pkg::M_STR_ESC ||
          p_mode == stl_pkg::M_CHR || p_mode == stl_pkg::M_CHR_ESC) begin
        res[n].kind  = (p_mode == stl_pkg::M_STR || p_mode == stl_pkg::M_STR_ESC) ?
                       stl_pkg::K_STR : stl_pkg::K_CHR;
        res[n].tfirst = !topen1;
        res[n].tlast  = 1'b1;
        n = n + 2'd1;
      end
      res[n].done = 1'b1;
      n = n + 2'd1;
      st_next          = '{mode: stl_pkg::M_IDLE, la_byte: 8'h00, la_valid: 1'b0,
                           topen: 1'b0};
      ident_count_next = '0;
    end else if (st.mode != stl_pkg::M_HALT) begin
      st_next = '{mode: p_mode, la_byte: char_in, la_valid: 1'b1, topen: topen1};
      if (ident_upd) begin
        ident_count_next = cnt_new;
      end
    end
    if (n != 2'd0) begin
      res[n - 2'd1].rlast = 1'b1;
    end
    res_n = n;
  end

endmodule

`default_nettype wire

/* rtl/stl_rq.sv */
// Result queue: takes up to three result words per cycle and gives out one per
// cycle unless rd_stall; uses stl_pkg for the result word type and depth constants.
`default_nettype none

module stl_rq (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    wr_n,
  input  stl_pkg::res_t wr_data [stl_pkg::MAX_RES],
  input  logic          rd_stall,
  output logic          rd_valid,
  output stl_pkg::res_t rd_data,
  output logic [$clog2(stl_pkg::RQ_DEPTH+1)-1:0] count
);

  localparam int PW  = $clog2(stl_pkg::RQ_DEPTH);
  localparam int CNW = $clog2(stl_pkg::RQ_DEPTH + 1);

  stl_pkg::res_t entries [stl_pkg::RQ_DEPTH];
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic           pop;
  logic [CNW-1:0] count_next;

  assign tail       = head + count[PW-1:0];
  assign rd_valid   = (count != '0);
  assign rd_data    = entries[head];
  assign pop        = rd_valid && !rd_stall;
  assign count_next = count + CNW'(wr_n) - CNW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < stl_pkg::MAX_RES; i++) begin
      if (2'(i) < wr_n) begin
        entries[tail + PW'(i)] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + PW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/source_token_lexer_core.sv */
// Streaming source lexer: one source byte per word in, tagged token bytes out.
// Top level; instantiates stl_step and stl_rq and uses stl_pkg.
//
// Input channel: in_valid / in_stall carry char_in and end_of_stream. Each byte is
// held back one word as lookahead, so a byte's result words appear when the next
// word (byte or end of stream) is taken. An end-of-stream word flushes the
// lookahead, closes an open quote and gives the done word, then the lexer is back
// in its reset state for a new stream.
// Output channel: out_valid / out_stall carry one result word per handshake; a word
// causes up to three result words, run_last marks the last of them.
// The words caused by an input word enter the result queue as it is taken.
// Throughput: one input word per cycle while the output keeps up; the lexer
// step is a single registered pass, and the four-entry result queue sets the
// pace: in_stall rises while more than one result word is waiting.
// When the receiver stalls the queue holds its words unchanged and in_stall stops
// the input once the queue cannot take three more.
// Reset (rst, synchronous): lexer idle between tokens, lookahead empty, queue empty.
// An unknown byte gives one error word; later bytes are taken and dropped until the
// end-of-stream word.
`default_nettype none

module source_token_lexer_core #(
  parameter int MAX_KEYWORD_LEN = stl_pkg::MAX_KW_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] token_kind,
  output logic [7:0] char_out,
  output logic       char_valid,
  output logic       token_first,
  output logic       token_last,
  output logic [3:0] keyword_id,
  output logic       error_flag,
  output logic       stream_done,
  output logic       run_last
);

  localparam int IW  = $clog2(MAX_KEYWORD_LEN);
  localparam int CW  = $clog2(MAX_KEYWORD_LEN + 2);
  localparam int CNW = $clog2(stl_pkg::RQ_DEPTH + 1);

  stl_pkg::lex_state_t st;
  stl_pkg::lex_state_t st_next;
  logic [CW-1:0]       ident_count;
  logic [CW-1:0]       ident_count_next;
  logic [7:0]          ident_store [MAX_KEYWORD_LEN];
  logic                store_we;
  logic [IW-1:0]       store_idx;
  stl_pkg::res_t       res [stl_pkg::MAX_RES];
  logic [1:0]          res_n;
  logic                accept;
  logic [CNW-1:0]      rq_count;
  stl_pkg::res_t       rd_data;

  assign in_stall = (rq_count > CNW'(stl_pkg::RQ_DEPTH - stl_pkg::MAX_RES));
  assign accept   = in_valid && !in_stall;

  stl_step #(
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
  ) u_step (
    .st               (st),
    .ident_count      (ident_count),
    .ident_store      (ident_store),
    .char_in          (char_in),
    .end_of_stream    (end_of_stream),
    .st_next          (st_next),
    .ident_count_next (ident_count_next),
    .store_we         (store_we),
    .store_idx        (store_idx),
    .res              (res),
    .res_n            (res_n)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '{mode: stl_pkg::M_IDLE, la_byte: 8'h00, la_valid: 1'b0, topen: 1'b0};
      ident_count <= '0;
    end else if (accept) begin
      st          <= st_next;
      ident_count <= ident_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      ident_store[store_idx] <= st.la_byte;
    end
  end

  stl_rq u_rq (
    .clk      (clk),
    .rst      (rst),
    .wr_n     (accept ? res_n : 2'd0),
    .wr_data  (res),
    .rd_stall (out_stall),
    .rd_valid (out_valid),
    .rd_data  (rd_data),
    .count    (rq_count)
  );

  assign token_kind  = rd_data.kind;
  assign char_out    = rd_data.ch;
  assign char_valid  = rd_data.cvalid;
  assign token_first = rd_data.tfirst;
  assign token_last  = rd_data.tlast;
  assign keyword_id  = rd_data.kw;
  assign error_flag  = rd_data.err;
  assign stream_done = rd_data.done;
  assign run_last    = rd_data.rlast;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for source_token_lexer_core: source text goes in word by
// word and every token word that comes out is checked against a lexer model kept here.
// Depends on stl_pkg for the result word layout and the kind and mode codes.

module testbench;
  import stl_pkg::*;

  localparam int MAX_KW      = 8;
  localparam int ITEM_TARGET = 480;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] token_kind;
  logic [7:0] char_out;
  logic       char_valid;
  logic       token_first;
  logic       token_last;
  logic [3:0] keyword_id;
  logic       error_flag;
  logic       stream_done;
  logic       run_last;

  // Lexer model state.
  mode_t      lex_mode;
  logic [7:0] la_byte;
  bit         la_valid;
  bit         tok_open;
  logic [7:0] id_buf [MAX_KW];
  int         id_len;

  res_t       step_words [$];
  res_t       token_words_due [$];
  res_t       due_word;
  res_t       got_word;
  logic [7:0] text_bytes [$];
  int         live_items = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         gaps_on = 1'b1;

  source_token_lexer_core #(.MAX_KEYWORD_LEN(MAX_KW)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .char_in(char_in), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_stall(out_stall),
    .token_kind(token_kind), .char_out(char_out), .char_valid(char_valid),
    .token_first(token_first), .token_last(token_last), .keyword_id(keyword_id),
    .error_flag(error_flag), .stream_done(stream_done), .run_last(run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- lexer model

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_ch(logic [7:0] c);
    return digit_ch(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit blank_ch(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  function automatic bit punct_ch(logic [7:0] c);
    case (c)
      ".", ",", ";", "(", ")", "{", "}", "[", "]": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit op_ch(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "%", "=", "&", "|", "<", ">", "!": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic string keyword_name(int k);
    case (k)
      0: return "ext";
      1: return "def";
      2: return "if";
      3: return "else";
      4: return "while";
      5: return "loop";
      6: return "for";
      7: return "break";
      8: return "continue";
      9: return "class";
      10: return "true";
      11: return "false";
      default: return "null";
    endcase
  endfunction

  function automatic logic [3:0] keyword_of_ident();
    string w;
    logic [3:0] hit;
    bit same;
    hit = 4'd0;
    if (id_len > MAX_KW) return 4'd0;
    for (int k = 0; k < KW_COUNT; k++) begin
      w = keyword_name(k);
      if (hit == 4'd0 && w.len() == id_len) begin
        same = 1'b1;
        for (int i = 0; i < id_len; i++) begin
          if (id_buf[i] != w[i]) same = 1'b0;
        end
        if (same) hit = 4'(k + 1);
      end
    end
    return hit;
  endfunction

  function automatic void clear_lexer();
    lex_mode = M_IDLE;
    la_byte = 8'h00;
    la_valid = 1'b0;
    tok_open = 1'b0;
    id_len = 0;
  endfunction

  function automatic void emit(kind_t kind, logic [7:0] ch, bit cv, bit last,
                               logic [3:0] kw, bit err, bit done);
    res_t r;
    if (step_words.size() >= MAX_RES) return;
    r = '0;
    r.kind = kind;
    r.ch = ch;
    r.cvalid = cv;
    r.kw = kw;
    r.err = err;
    r.done = done;
    if (kind != K_NONE) begin
      r.tfirst = !tok_open;
      r.tlast = last;
      tok_open = !last;
    end
    step_words.push_back(r);
  endfunction

  function automatic void run_tok(kind_t kind, mode_t mode, logic [7:0] c,
                                  logic [7:0] nx, bit hn);
    bit more;
    logic [3:0] kw;
    case (kind)
      K_NUM: more = hn && (digit_ch(nx) || nx == CH_MINUS);
      K_IDENT: more = hn && word_ch(nx);
      default: more = hn && op_ch(nx);
    endcase
    kw = 4'd0;
    if (kind == K_IDENT) begin
      if (!tok_open) id_len = 0;
      if (id_len < MAX_KW) id_buf[id_len] = c;
      // The count saturates one past the store so long names never match.
      if (id_len <= MAX_KW) id_len++;
      if (!more) kw = keyword_of_ident();
    end
    emit(kind, c, 1'b1, !more, kw, 1'b0, 1'b0);
    lex_mode = more ? mode : M_IDLE;
  endfunction

  function automatic void quoted(kind_t kind, mode_t esc_mode, logic [7:0] quote,
                                 logic [7:0] c);
    if (c == CH_BSLASH) begin
      lex_mode = esc_mode;
    end else if (c == quote) begin
      emit(kind, 8'h00, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0);
      lex_mode = M_IDLE;
    end else begin
      emit(kind, c, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic [7:0] nx, bit hn);
    case (lex_mode)
      M_IDLE: begin
        if (!blank_ch(c)) begin
          if (c == CH_SLASH && hn && nx == CH_SLASH) begin
            lex_mode = M_LC_OPEN;
          end else if (c == CH_SLASH && hn && nx == CH_STAR) begin
            lex_mode = M_BC_OPEN;
          end else if (c == CH_DQUOTE) begin
            tok_open = 1'b0;
            lex_mode = M_STR;
          end else if (c == CH_SQUOTE) begin
            tok_open = 1'b0;
            lex_mode = M_CHR;
          end else begin
            tok_open = 1'b0;
            if (digit_ch(c) || (c == CH_MINUS && hn && digit_ch(nx))) begin
              run_tok(K_NUM, M_NUM, c, nx, hn);
            end else if (word_ch(c)) begin
              run_tok(K_IDENT, M_IDENT, c, nx, hn);
            end else if (punct_ch(c)) begin
              emit(K_PUNC, c, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0);
            end else if (op_ch(c)) begin
              run_tok(K_OP, M_OP, c, nx, hn);
            end else begin
              emit(K_NONE, c, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0);
              lex_mode = M_HALT;
            end
          end
        end
      end
      M_NUM: run_tok(K_NUM, M_NUM, c, nx, hn);
      M_IDENT: run_tok(K_IDENT, M_IDENT, c, nx, hn);
      M_OP: run_tok(K_OP, M_OP, c, nx, hn);
      M_STR: quoted(K_STR, M_STR_ESC, CH_DQUOTE, c);
      M_CHR: quoted(K_CHR, M_CHR_ESC, CH_SQUOTE, c);
      M_STR_ESC: begin
        emit(K_STR, c, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        lex_mode = M_STR;
      end
      M_CHR_ESC: begin
        emit(K_CHR, c, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        lex_mode = M_CHR;
      end
      M_LC_OPEN: lex_mode = M_LC;
      M_LC: if (c == CH_NL) lex_mode = M_IDLE;
      M_BC_OPEN: lex_mode = M_BC;
      M_BC: if (c == CH_STAR && hn && nx == CH_SLASH) lex_mode = M_BC_CLOSE;
      M_BC_CLOSE: lex_mode = M_IDLE;
      default: ;
    endcase
  endfunction

  // Works out the result words of one accepted word and queues them.
  function automatic void lex_word(logic [7:0] c, bit eos);
    res_t w;
    step_words.delete();
    live_items++;
    if (eos) begin
      if (la_valid && lex_mode != M_HALT) lex_byte(la_byte, 8'h00, 1'b0);
      if (lex_mode == M_STR || lex_mode == M_STR_ESC) begin
        emit(K_STR, 8'h00, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0);
      end else if (lex_mode == M_CHR || lex_mode == M_CHR_ESC) begin
        emit(K_CHR, 8'h00, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0);
      end
      emit(K_NONE, 8'h00, 1'b0, 1'b0, 4'd0, 1'b0, 1'b1);
      clear_lexer();
    end else if (lex_mode != M_HALT) begin
      if (la_valid) lex_byte(la_byte, c, 1'b1);
      la_byte = c;
      la_valid = 1'b1;
    end
    for (int i = 0; i < step_words.size(); i++) begin
      w = step_words[i];
      w.rlast = (i == step_words.size() - 1);
      token_words_due.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string word_text(res_t w);
    return $sformatf("kind %0d char %02h cv %b first %b last %b kw %0d err %b done %b rl %b",
                     w.kind, w.ch, w.cvalid, w.tfirst, w.tlast, w.kw, w.err, w.done,
                     w.rlast);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_word = {token_kind, char_out, char_valid, token_first, token_last, keyword_id,
                  error_flag, stream_done, run_last};
      if (token_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %s", word_text(got_word));
      end else begin
        due_word = token_words_due.pop_front();
        if (got_word !== due_word) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch at cycle %0d", cycle_count);
            $display("  expected %s", word_text(due_word));
            $display("  actual   %s", word_text(got_word));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 6);
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_word(logic [7:0] c, bit eos);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    lex_word(c, eos);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    drop_valid();
    while (token_words_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_word_ch(bit lead);
    int r;
    r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(0, 8))
      0: return ".";
      1: return ",";
      2: return ";";
      3: return "(";
      4: return ")";
      5: return "{";
      6: return "}";
      7: return "[";
      default: return "]";
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 10))
      0: return "+";
      1: return "-";
      2: return "*";
      3: return "/";
      4: return "%";
      5: return "=";
      6: return "&";
      7: return "|";
      8: return "<";
      9: return ">";
      default: return "!";
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic void push_quoted_body();
    int n;
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          text_bytes.push_back(CH_BSLASH);
          text_bytes.push_back(8'($urandom_range(0, 255)));
        end
        2, 3: text_bytes.push_back(8'($urandom_range(0, 255)));
        default: text_bytes.push_back(8'($urandom_range(32, 126)));
      endcase
    end
  endfunction

  // Appends one random token, comment or stray byte to text_bytes.
  function automatic void push_token();
    string w;
    int n;
    int pick;
    pick = $urandom_range(0, 96);
    if (pick < 15) begin
      w = keyword_name($urandom_range(0, KW_COUNT - 1));
      for (int i = 0; i < w.len(); i++) text_bytes.push_back(w[i]);
      if ($urandom_range(0, 3) == 0) text_bytes.push_back(rand_word_ch(1'b0));
    end else if (pick < 30) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
      text_bytes.push_back(rand_word_ch(1'b1));
      for (int i = 1; i < n; i++) text_bytes.push_back(rand_word_ch(1'b0));
    end else if (pick < 40) begin
      if ($urandom_range(0, 2) == 0) text_bytes.push_back(CH_MINUS);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 4) == 0) text_bytes.push_back(CH_MINUS);
        text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      end
    end else if (pick < 50) begin
      text_bytes.push_back(CH_DQUOTE);
      push_quoted_body();
      if ($urandom_range(0, 9) != 0) text_bytes.push_back(CH_DQUOTE);
    end else if (pick < 55) begin
      text_bytes.push_back(CH_SQUOTE);
      push_quoted_body();
      if ($urandom_range(0, 9) != 0) text_bytes.push_back(CH_SQUOTE);
    end else if (pick < 65) begin
      text_bytes.push_back(rand_punct());
    end else if (pick < 75) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) text_bytes.push_back(rand_op());
    end else if (pick < 85) begin
      text_bytes.push_back(rand_blank());
    end else if (pick < 90) begin
      text_bytes.push_back(CH_SLASH);
      text_bytes.push_back(CH_SLASH);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) text_bytes.push_back(8'($urandom_range(0, 255)));
      text_bytes.push_back(CH_NL);
    end else if (pick < 95) begin
      text_bytes.push_back(CH_SLASH);
      text_bytes.push_back(CH_STAR);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) text_bytes.push_back(8'($urandom_range(0, 255)));
      text_bytes.push_back(CH_STAR);
      text_bytes.push_back(CH_SLASH);
    end else begin
      // Any byte at all; most of these halt the lexer until end of stream.
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0) text_bytes.push_back(rand_blank());
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_empty_stream();
    send_word(8'h00, 1'b1);
  endtask

  // Keyword, negative number, punctuation, identifier and an operator run.
  task automatic test_token_kinds();
    send_text("if-3;x+=");
    send_word(8'hFF, 1'b1);
  endtask

  // Escaped quote in a char literal, then a string left open at end of stream.
  task automatic test_quotes_and_escapes();
    send_text("'\\''\"");
    send_eos();
  endtask

  // Nine-byte name is never a keyword; the stream ends inside a block comment.
  task automatic test_long_ident_open_comment();
    send_text("continues/*");
    send_eos();
  endtask

  // An unknown byte halts the lexer; later bytes are dropped until end of stream.
  task automatic test_bad_byte_halt();
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word("a", 1'b0);
    send_eos();
  endtask

  task automatic test_random_source();
    bit drained;
    drained = 1'b0;
    while (live_items < ITEM_TARGET) begin
      gaps_on = !(live_items >= 200 && live_items < 320);
      if (!drained && live_items >= 350) begin
        wait_drain();
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 4) begin
        send_eos();
      end else begin
        push_token();
        while (text_bytes.size() != 0) send_word(text_bytes.pop_front(), 1'b0);
      end
    end
    gaps_on = 1'b1;
    send_eos();
  endtask

  initial begin
    clear_lexer();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_stream();
    test_token_kinds();
    test_quotes_and_escapes();
    test_long_ident_open_comment();
    test_bad_byte_halt();
    wait_drain();
    test_random_source();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && token_words_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
